// ===== rtl/qalu_pkg.sv =====
// qalu_pkg: opcodes, constants and stage payload types for the q16.16 alu
// no dependencies; used by every file of the block
package qalu_pkg;

	localparam logic [3:0] OP_ADD      = 4'd0;
	localparam logic [3:0] OP_SUB      = 4'd1;
	localparam logic [3:0] OP_MUL      = 4'd2;
	localparam logic [3:0] OP_DIV      = 4'd3;
	localparam logic [3:0] OP_MOD      = 4'd4;
	localparam logic [3:0] OP_CMP      = 4'd5;
	localparam logic [3:0] OP_TRUNC    = 4'd6;
	localparam logic [3:0] OP_ROUND    = 4'd7;
	localparam logic [3:0] OP_FROM_INT = 4'd8;

	localparam int DVD_W     = 48;
	localparam int DIV_STEPS = DVD_W;

	localparam logic [31:0] SAT_MAX  = 32'h7fffffff;
	localparam logic [31:0] SAT_MIN  = 32'h80000000;
	localparam logic [33:0] HALF_LSB = 34'h8000;
	localparam logic [33:0] FRAC_RND = 34'hffff;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic               a_neg;
		logic               q_neg;
		logic               b_zero;
		logic [31:0]        mag_a;
		logic [31:0]        mag_b;
	} cls_t;

	typedef struct packed {
		logic [3:0]  op;
		logic        a_neg;
		logic        q_neg;
		logic        b_zero;
		logic [31:0] res;
		logic        lt;
		logic        eq;
		logic        gt;
	} side_t;

endpackage

// ===== rtl/q16_16_fixed_point_alu_core.sv =====
// q16_16_fixed_point_alu_core: top level of the signed q16.16 arithmetic unit
// depends on qalu_pkg, qalu_front, qalu_back
//
//  channel  | handshake       | beat
//  command  | start / busy    | op, operand_a, operand_b
//  result   | done (strobe)   | result_value, is_less, is_equal, is_greater, zero_divisor
//
// one command per cycle while busy is low; results pass the queue and every stage
// pipeline depth is set by the 48-stage restoring divider, one quotient bit per stage
// every operation runs through the same pipeline so results leave in command order
// reset clears the queue and all stage valids; payload registers are not reset
// the receiver cannot stall, so busy only rises if the two-entry queue fills
module q16_16_fixed_point_alu_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [3:0]         op,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               busy,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic               is_less,
	output logic               is_equal,
	output logic               is_greater,
	output logic               zero_divisor
);
	import qalu_pkg::*;

	cls_t head;
	logic head_valid;

	qalu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (op),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.busy       (busy),
		.head_valid (head_valid),
		.head       (head)
	);

	qalu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.done         (done),
		.result_value (result_value),
		.is_less      (is_less),
		.is_equal     (is_equal),
		.is_greater   (is_greater),
		.zero_divisor (zero_divisor)
	);

endmodule

// ===== rtl/qalu_front.sv =====
// qalu_front: takes commands, classifies operands, holds them in a two-entry queue
// depends on qalu_pkg
module qalu_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [3:0]          op,
	input  logic signed [31:0]  operand_a,
	input  logic signed [31:0]  operand_b,
	output logic                busy,
	output logic                head_valid,
	output qalu_pkg::cls_t      head
);
	import qalu_pkg::*;

	cls_t       fifo_q [0:1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cls_t       cls;
	logic       push;
	logic       pop;

	always_comb begin
		cls.op     = op;
		cls.a      = operand_a;
		cls.b      = operand_b;
		cls.a_neg  = operand_a[31];
		cls.q_neg  = operand_a[31] ^ operand_b[31];
		cls.b_zero = (operand_b == 32'sd0);
		cls.mag_a  = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
		cls.mag_b  = operand_b[31] ? (~operand_b + 32'd1) : operand_b;
	end

	assign busy       = (count_q == 2'd2);
	assign push       = start && !busy;
	assign head_valid = (count_q != 2'd0);
	assign pop        = head_valid;
	assign head       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/qalu_back.sv =====
// qalu_back: combinational simple ops, registered multiplier and a bit-per-stage pipelined divider
// depends on qalu_pkg; fed by qalu_front
module qalu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  qalu_pkg::cls_t      head,
	output logic                done,
	output logic signed [31:0]  result_value,
	output logic                is_less,
	output logic                is_equal,
	output logic                is_greater,
	output logic                zero_divisor
);
	import qalu_pkg::*;

	logic               vld_s  [0:DIV_STEPS];
	side_t              side_s [0:DIV_STEPS];
	logic [31:0]        rem_s  [0:DIV_STEPS];
	logic [DVD_W-1:0]   dq_s   [0:DIV_STEPS];
	logic [31:0]        dv_s   [0:DIV_STEPS];
	logic signed [63:0] prod_s1;

	side_t              side_in;
	logic [33:0]        a_x;
	logic [33:0]        rnd;
	logic [33:0]        tr_x;
	logic [33:0]        rn_x;
	logic signed [63:0] prod_fix;
	logic [DVD_W-1:0]   q_signed;
	logic [31:0]        r_signed;
	logic [31:0]        res_out;

	always_comb begin
		a_x  = {{2{head.a[31]}}, head.a};
		tr_x = head.a_neg ? (a_x + FRAC_RND) : a_x;
		rnd  = head.a_neg ? (a_x - HALF_LSB) : (a_x + HALF_LSB);
		rn_x = rnd[33] ? (rnd + FRAC_RND) : rnd;
		side_in.op     = head.op;
		side_in.a_neg  = head.a_neg;
		side_in.q_neg  = head.q_neg;
		side_in.b_zero = head.b_zero;
		side_in.res    = 32'd0;
		side_in.lt     = 1'b0;
		side_in.eq     = 1'b0;
		side_in.gt     = 1'b0;
		case (head.op)
			OP_ADD:      side_in.res = head.a + head.b;
			OP_SUB:      side_in.res = head.a - head.b;
			OP_DIV:      side_in.res = head.a_neg ? SAT_MIN : SAT_MAX;
			OP_MOD:      side_in.res = head.a;
			OP_CMP: begin
				side_in.lt = (head.a < head.b);
				side_in.eq = (head.a == head.b);
				side_in.gt = (head.a > head.b);
			end
			OP_TRUNC:    side_in.res = {{16{tr_x[31]}}, tr_x[31:16]};
			OP_ROUND:    side_in.res = {{16{rn_x[31]}}, rn_x[31:16]};
			OP_FROM_INT: side_in.res = {head.a[15:0], 16'd0};
			default:     side_in.res = 32'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		prod_s1   <= head.a * head.b;
		rem_s[0]  <= 32'd0;
		dq_s[0]   <= (head.op == OP_MOD) ? {16'd0, head.mag_a} : {head.mag_a, 16'd0};
		dv_s[0]   <= head.mag_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= head_valid;
		end
	end

	assign prod_fix = prod_s1[63] ? (prod_s1 + 64'sd65535) : prod_s1;

	genvar k;
	generate
		for (k = 1; k <= DIV_STEPS; k++) begin : g_step
			logic [32:0] t;
			logic [32:0] df;
			logic        ge;
			side_t       nxt;

			assign t  = {rem_s[k-1], dq_s[k-1][DVD_W-1]};
			assign df = t - {1'b0, dv_s[k-1]};
			assign ge = !df[32];

			always_comb begin
				nxt = side_s[k-1];
				if (k == 1 && side_s[k-1].op == OP_MUL) begin
					nxt.res = prod_fix[47:16];
				end
			end

			always_ff @(posedge clk) begin
				side_s[k] <= nxt;
				rem_s[k]  <= ge ? df[31:0] : t[31:0];
				dq_s[k]   <= {dq_s[k-1][DVD_W-2:0], ge};
				dv_s[k]   <= dv_s[k-1];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	endgenerate

	always_comb begin
		q_signed = side_s[DIV_STEPS].q_neg ? (~dq_s[DIV_STEPS] + 48'd1) : dq_s[DIV_STEPS];
		r_signed = side_s[DIV_STEPS].a_neg ? (~rem_s[DIV_STEPS] + 32'd1) : rem_s[DIV_STEPS];
		res_out  = side_s[DIV_STEPS].res;
		if (!side_s[DIV_STEPS].b_zero) begin
			if (side_s[DIV_STEPS].op == OP_DIV) begin
				res_out = q_signed[31:0];
			end else if (side_s[DIV_STEPS].op == OP_MOD) begin
				res_out = r_signed;
			end
		end
	end

	always_ff @(posedge clk) begin
		result_value <= res_out;
		is_less      <= side_s[DIV_STEPS].lt;
		is_equal     <= side_s[DIV_STEPS].eq;
		is_greater   <= side_s[DIV_STEPS].gt;
		zero_divisor <= side_s[DIV_STEPS].b_zero &&
			(side_s[DIV_STEPS].op == OP_DIV || side_s[DIV_STEPS].op == OP_MOD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[DIV_STEPS];
		end
	end

	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0({is_less, is_equal, is_greater}))
		else $error("compare flags not exclusive");
	a_zd_no_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_divisor) |-> !(is_less || is_equal || is_greater))
		else $error("zero divisor with compare flags");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_STEPS] |=> done)
		else $error("finished item not presented");

endmodule

// ===== tb/q16_16_fixed_point_alu_checker.sv =====
// q16_16_fixed_point_alu_checker: predicts every q16.16 alu result and compares it with the dut
// depends on qalu_pkg; watches the command and result ports of q16_16_fixed_point_alu_core
module q16_16_fixed_point_alu_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [3:0]         op,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	input  logic               done,
	input  logic signed [31:0] result_value,
	input  logic               is_less,
	input  logic               is_equal,
	input  logic               is_greater,
	input  logic               zero_divisor,
	output int                 fail_count,
	output int                 pending,
	output int                 beats_taken,
	output int                 results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import qalu_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic        lt;
		logic        eq;
		logic        gt;
		logic        zd;
	} alu_result_t;

	alu_result_t result_q[$];

	function automatic alu_result_t alu_predict(logic [3:0] code, logic signed [31:0] a32,
		logic signed [31:0] b32);
		alu_result_t r;
		longint a;
		longint b;
		longint t;
		r = '0;
		a = a32;
		b = b32;
		case (code)
			OP_ADD: r.value = 32'(a + b);
			OP_SUB: r.value = 32'(a - b);
			OP_MUL: r.value = 32'((a * b) / 65536);
			OP_DIV: begin
				if (b == 0) begin
					r.zd = 1'b1;
					r.value = (a < 0) ? SAT_MIN : SAT_MAX;
				end else begin
					r.value = 32'((a * 65536) / b);
				end
			end
			OP_MOD: begin
				if (b == 0) begin
					r.zd = 1'b1;
					r.value = a32;
				end else begin
					r.value = 32'(a % b);
				end
			end
			OP_CMP: begin
				r.lt = a < b;
				r.eq = a == b;
				r.gt = a > b;
			end
			OP_TRUNC: begin
				t = a / 65536;
				r.value = {{16{t[15]}}, t[15:0]};
			end
			OP_ROUND: begin
				t = ((a < 0) ? (a - 32768) : (a + 32768)) / 65536;
				r.value = {{16{t[15]}}, t[15:0]};
			end
			OP_FROM_INT: r.value = 32'(a * 65536);
			default: r = '0;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alu_result_t e;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			beats_taken <= 0;
			results_seen <= 0;
		end else begin
			if (start && !busy) begin
				result_q.push_back(alu_predict(op, operand_a, operand_b));
				beats_taken <= beats_taken + 1;
			end
			if (done) begin
				results_seen <= results_seen + 1;
				if (result_q.size() == 0) begin
					$error("result with no command outstanding: %h", result_value);
					fail_count <= fail_count + 1;
				end else begin
					e = result_q.pop_front();
					if (e.value !== result_value || e.lt !== is_less || e.eq !== is_equal
						|| e.gt !== is_greater || e.zd !== zero_divisor)
						fail_count <= fail_count + 1;
					if (e.value !== result_value)
						$error("result_value expected %h actual %h", e.value, result_value);
					if (e.lt !== is_less)
						$error("is_less expected %b actual %b", e.lt, is_less);
					if (e.eq !== is_equal)
						$error("is_equal expected %b actual %b", e.eq, is_equal);
					if (e.gt !== is_greater)
						$error("is_greater expected %b actual %b", e.gt, is_greater);
					if (e.zd !== zero_divisor)
						$error("zero_divisor expected %b actual %b", e.zd, zero_divisor);
				end
			end
			pending <= result_q.size();
		end
	end
endmodule

// ===== tb/tb_q16_16_fixed_point_alu_core.sv =====
// tb_q16_16_fixed_point_alu_core: drives directed and random commands into the q16.16 alu
// depends on qalu_pkg, q16_16_fixed_point_alu_core and q16_16_fixed_point_alu_checker
module tb_q16_16_fixed_point_alu_core;
	timeunit 1ns;
	timeprecision 1ps;
	import qalu_pkg::*;

	localparam int WATCHDOG = 2000;
	localparam int DRAIN    = 60;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [3:0]         op = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic               busy, done;
	logic signed [31:0] result_value;
	logic               is_less, is_equal, is_greater, zero_divisor;
	int                 fail_count, pending, beats_taken, results_seen;
	int                 idle_pct;
	int                 quiet;

	always #4 clk = ~clk;

	q16_16_fixed_point_alu_core dut (.*);
	q16_16_fixed_point_alu_checker checker_i (.*);

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return SAT_MIN;
			1: return SAT_MAX;
			2: return '0;
			3: return {{16{1'b0}}, 16'h0} + ($urandom_range(0, 1) ? 32'hffffffff : 32'h1);
			4: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
			5: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'h8000};
			6: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_cmd(logic [3:0] code, logic [31:0] a, logic [31:0] b);
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= code;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [3:0] code;
		idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_cmd(OP_ADD, SAT_MAX, 32'h1);
		send_cmd(OP_SUB, SAT_MIN, 32'h1);
		send_cmd(OP_MUL, SAT_MIN, SAT_MIN);
		send_cmd(OP_MUL, 32'hffff0000, 32'h00008000);
		send_cmd(OP_MUL, 32'hffffffff, 32'h00000001);
		send_cmd(OP_DIV, 32'h00050000, '0);
		send_cmd(OP_DIV, 32'hfffb0000, '0);
		send_cmd(OP_DIV, SAT_MIN, 32'hffffffff);
		send_cmd(OP_DIV, SAT_MAX, 32'h1);
		send_cmd(OP_DIV, 32'hfffffff9, 32'h00020000);
		send_cmd(OP_MOD, 32'h12345, '0);
		send_cmd(OP_MOD, SAT_MIN, 32'hffffffff);
		send_cmd(OP_MOD, 32'hfffffff9, 32'h2);
		send_cmd(OP_CMP, SAT_MIN, SAT_MAX);
		send_cmd(OP_CMP, 32'h1234, 32'h1234);
		send_cmd(OP_CMP, SAT_MAX, SAT_MIN);
		send_cmd(OP_TRUNC, 32'hfffe8000, '0);
		send_cmd(OP_TRUNC, SAT_MAX, SAT_MIN);
		send_cmd(OP_ROUND, 32'h00018000, '0);
		send_cmd(OP_ROUND, 32'hfffe8000, '0);
		send_cmd(OP_ROUND, SAT_MAX, '0);
		send_cmd(OP_ROUND, SAT_MIN, '0);
		send_cmd(OP_FROM_INT, 32'h00007fff, '0);
		send_cmd(OP_FROM_INT, SAT_MIN, SAT_MAX);
		send_cmd(4'hf, SAT_MAX, SAT_MAX);
		for (int i = 0; i < 450; i++) begin
			case (i / 113)
				0: idle_pct = 0;
				1: idle_pct = 78;
				2: idle_pct = 22;
				default: idle_pct = $urandom_range(0, 1) ? 0 : 50;
			endcase
			code = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			send_cmd(code, pick_operand(), ($urandom_range(0, 9) == 0) ? '0 : pick_operand());
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("covered %0d commands over all opcodes, %0d results checked",
			beats_taken, results_seen);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
